// ===== sv/tcrtc_pkg.sv =====
// Shared types, register indexes and constants of the text CRT timing controller.
package tcrtc_pkg;

  // Transaction codes carried on the input channel
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // I/O port offsets with a meaning of their own
  localparam logic [3:0] PORT_MODE   = 4'd8;
  localparam logic [3:0] PORT_STATUS = 4'd10;

  // CRTC register indexes
  localparam logic [4:0] R_H_DISP    = 5'd1;
  localparam logic [4:0] R_V_TOTAL   = 5'd4;
  localparam logic [4:0] R_V_ADJ     = 5'd5;
  localparam logic [4:0] R_V_DISP    = 5'd6;
  localparam logic [4:0] R_V_SYNC    = 5'd7;
  localparam logic [4:0] R_LACE_MODE = 5'd8;
  localparam logic [4:0] R_MAX_SCAN  = 5'd9;
  localparam logic [4:0] R_CUR_START = 5'd10;
  localparam logic [4:0] R_CUR_END   = 5'd11;
  localparam logic [4:0] R_START_HI  = 5'd12;
  localparam logic [4:0] R_START_LO  = 5'd13;

  localparam int unsigned NUM_REGS = 32;

  // Cursor shape fix-up: this start/end pair is replaced by the fixed pair
  localparam logic [7:0] CUR_FIX_START_IN  = 8'h06;
  localparam logic [7:0] CUR_FIX_END_IN    = 8'h07;
  localparam logic [7:0] CUR_FIX_START_OUT = 8'h0b;
  localparam logic [7:0] CUR_FIX_END_OUT   = 8'h0c;

  // Status byte: upper nibble always reads as ones
  localparam logic [3:0] STATUS_HI_ONES = 4'hf;
  localparam logic [7:0] READ_NONE      = 8'hff;

  // Mode control bit that lets attribute blink through
  localparam int unsigned MODE_BLINK_BIT = 5;

  // Lines of vertical sync after the sync row is reached
  localparam int unsigned VSYNC_LINES = 16;
  localparam logic [4:0]  VSYNC_LOAD  = 5'(VSYNC_LINES);

  // Timing state advanced by half-line ticks
  typedef struct packed {
    logic        hretrace;
    logic        vsync;
    logic        line_phase;
    logic [6:0]  row;
    logic [4:0]  scan;
    logic [15:0] addr;
    logic [15:0] row_start;
    logic        cursor_window;
    logic        cursor_phase;
    logic        disp_active;
    logic [4:0]  blink;
    logic [4:0]  vsync_left;
    logic [7:0]  vadj_left;
  } timing_t;

  // CRTC registers that the timing logic looks at
  typedef struct packed {
    logic [7:0] h_disp;
    logic [7:0] v_total;
    logic [7:0] v_adj;
    logic [7:0] v_disp;
    logic [7:0] v_sync;
    logic [7:0] lace_mode;
    logic [7:0] max_scan;
    logic [7:0] cur_start;
    logic [7:0] cur_end;
    logic [7:0] start_hi;
    logic [7:0] start_lo;
  } crtc_view_t;

endpackage

// ===== sv/tcrtc_if.sv =====
// Valid/ready channel interfaces for the CRTC input and result beats.
interface tcrtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] port_offset;
  logic [7:0] write_data;

  modport source (output valid, output op, output port_offset, output write_data,
                  input ready);
  modport sink   (input valid, input op, input port_offset, input write_data,
                  output ready);
endinterface

interface tcrtc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [15:0] row_address;
  logic [4:0]  scanline;
  logic        display_enable;
  logic        cursor_enable;
  logic        attr_blink_on;
  logic        vsync;
  logic        hretrace;

  modport source (output valid, output read_data, output row_address, output scanline,
                  output display_enable, output cursor_enable, output attr_blink_on,
                  output vsync, output hretrace, input ready);
  modport sink   (input valid, input read_data, input row_address, input scanline,
                  input display_enable, input cursor_enable, input attr_blink_on,
                  input vsync, input hretrace, output ready);
endinterface

// ===== sv/text_crtc_timing_controller.sv =====
// Text-mode CRT controller: register file, port decode and result register.
//
// Usage: one input channel carries beats of op, port_offset and write_data:
// a port write (index, register data or mode control), a port read (index,
// register data, status or an unused port) or a half-line tick. Ticks
// alternate between line start and line end and advance the raster timing.
// Every accepted beat gives exactly one result beat on the output channel:
// read_data for a read (zero otherwise) and the timing fields as they stood
// before the beat.
// Latency: the result is valid in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the receiver keeps ready high; the whole update is one pass of logic
// between the input handshake and the result register.
// Reset: all registers, the index, mode control, status and the timing
// counters clear at once; the block takes beats in the first cycle after.
// Stall: while a result waits unread, no new beat is taken; the input is
// ready again in the cycle the waiting result is taken.
module text_crtc_timing_controller
  import tcrtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tcrtc_in_if.sink    in_i,
  tcrtc_out_if.source out_o
);

  logic [7:0] regs_q [NUM_REGS];
  logic [7:0] regs_d [NUM_REGS];
  logic [4:0] idx_q, idx_d;
  logic [7:0] mode_q, mode_d;
  timing_t    tim_q, tim_d, tim_tick;
  crtc_view_t view;

  logic       accept;
  logic       is_reg_port;
  logic       is_idx_port;
  logic [7:0] rd_data;
  op_e        op;

  logic        out_valid_q;
  logic [7:0]  rd_q;
  logic [15:0] row_addr_q;
  logic [4:0]  scan_q;
  logic        disp_q, cur_q, blink_q, vs_q, hr_q;

  // Take a beat when the result register is empty or being emptied
  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign accept      = in_i.valid & in_i.ready;
  assign op          = op_e'(in_i.op);
  assign is_reg_port = ~in_i.port_offset[3];
  assign is_idx_port = is_reg_port & ~in_i.port_offset[0];

  // Registers seen by the timing logic
  assign view = '{
    h_disp:    regs_q[R_H_DISP],
    v_total:   regs_q[R_V_TOTAL],
    v_adj:     regs_q[R_V_ADJ],
    v_disp:    regs_q[R_V_DISP],
    v_sync:    regs_q[R_V_SYNC],
    lace_mode: regs_q[R_LACE_MODE],
    max_scan:  regs_q[R_MAX_SCAN],
    cur_start: regs_q[R_CUR_START],
    cur_end:   regs_q[R_CUR_END],
    start_hi:  regs_q[R_START_HI],
    start_lo:  regs_q[R_START_LO]
  };

  tcrtc_line_timing u_line_timing (
    .cur_i  (tim_q),
    .regs_i (view),
    .nxt_o  (tim_tick)
  );

  // Decode the beat: register writes, reads and ticks
  always_comb begin
    regs_d  = regs_q;
    idx_d   = idx_q;
    mode_d  = mode_q;
    tim_d   = tim_q;
    rd_data = 8'h00;
    unique case (op)
      OP_WRITE: begin
        if (is_idx_port) begin
          idx_d = in_i.write_data[4:0];
        end else if (is_reg_port) begin
          regs_d[idx_q] = in_i.write_data;
          if ((regs_d[R_CUR_START] == CUR_FIX_START_IN) &&
              (regs_d[R_CUR_END] == CUR_FIX_END_IN)) begin
            regs_d[R_CUR_START] = CUR_FIX_START_OUT;
            regs_d[R_CUR_END]   = CUR_FIX_END_OUT;
          end
        end else if (in_i.port_offset == PORT_MODE) begin
          mode_d = in_i.write_data;
        end
      end
      OP_READ: begin
        if (is_idx_port) begin
          rd_data = {3'b000, idx_q};
        end else if (is_reg_port) begin
          rd_data = regs_q[idx_q];
        end else if (in_i.port_offset == PORT_STATUS) begin
          rd_data = {STATUS_HI_ONES, tim_q.vsync, 2'b00, tim_q.hretrace};
        end else begin
          rd_data = READ_NONE;
        end
      end
      OP_TICK: begin
        tim_d = tim_tick;
      end
      default: begin
      end
    endcase
  end

  // Update block state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= 8'h00;
      end
      idx_q  <= '0;
      mode_q <= '0;
      tim_q  <= '0;
    end else if (accept) begin
      regs_q <= regs_d;
      idx_q  <= idx_d;
      mode_q <= mode_d;
      tim_q  <= tim_d;
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q       <= rd_data;
      row_addr_q <= tim_q.addr;
      scan_q     <= tim_q.scan;
      disp_q     <= tim_q.disp_active;
      cur_q      <= tim_q.cursor_window & tim_q.cursor_phase;
      blink_q    <= tim_q.blink[4] & mode_q[MODE_BLINK_BIT];
      vs_q       <= tim_q.vsync;
      hr_q       <= tim_q.hretrace;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_data      = rd_q;
  assign out_o.row_address    = row_addr_q;
  assign out_o.scanline       = scan_q;
  assign out_o.display_enable = disp_q;
  assign out_o.cursor_enable  = cur_q;
  assign out_o.attr_blink_on  = blink_q;
  assign out_o.vsync          = vs_q;
  assign out_o.hretrace       = hr_q;

endmodule

// ===== sv/tcrtc_line_timing.sv =====
// Next-state logic of the raster timing for one half-line tick.
module tcrtc_line_timing
  import tcrtc_pkg::*;
(
  input  timing_t    cur_i,
  input  crtc_view_t regs_i,
  output timing_t    nxt_o
);

  // Scanline match, with the halved target also matching in interlace mode
  function automatic logic scan_hit(input logic [4:0] scan, input logic [7:0] target,
                                    input logic lace);
    logic [7:0] s;
    s = {3'b000, scan};
    return (s == target) || (lace && (s == (target >> 1)));
  endfunction

  logic        lace;
  logic [15:0] start_addr;
  logic [6:0]  row_inc;
  logic [6:0]  row_new;
  logic        wrap;
  timing_t     t;

  assign lace       = (regs_i.lace_mode[1:0] == 2'b11);
  assign start_addr = {2'b00, regs_i.start_hi[5:0], regs_i.start_lo};
  assign row_inc    = cur_i.row + 7'd1;
  assign wrap       = ({1'b0, cur_i.row} == regs_i.v_total);
  assign row_new    = wrap ? 7'd0 : row_inc;

  always_comb begin
    t = cur_i;
    if (!cur_i.line_phase) begin
      // Line start: enter retrace, step the address, raise vsync on the sync row
      t.hretrace   = 1'b1;
      t.line_phase = 1'b1;
      if (cur_i.disp_active) begin
        t.addr = cur_i.addr + {8'h00, regs_i.h_disp};
      end
      if (({1'b0, cur_i.row} == regs_i.v_sync) && (cur_i.scan == 5'd0)) begin
        t.vsync = 1'b1;
      end
    end else begin
      // Line end: leave retrace if the display is active, count down vsync, close the cursor window
      if (cur_i.disp_active) begin
        t.hretrace = 1'b0;
      end
      t.line_phase = 1'b0;
      if (cur_i.vsync_left != 5'd0) begin
        t.vsync_left = cur_i.vsync_left - 5'd1;
        if (cur_i.vsync_left == 5'd1) begin
          t.vsync = 1'b0;
        end
      end
      if (scan_hit(cur_i.scan, {3'b000, regs_i.cur_end[4:0]}, lace)) begin
        t.cursor_window = 1'b0;
      end

      // Advance scanline, row and vertical adjust
      if (cur_i.vadj_left != 8'd0) begin
        t.scan      = cur_i.scan + 5'd1;
        t.addr      = cur_i.row_start;
        t.vadj_left = cur_i.vadj_left - 8'd1;
        if (cur_i.vadj_left == 8'd1) begin
          t.disp_active = 1'b1;
          t.addr        = start_addr;
          t.row_start   = start_addr;
          t.scan        = 5'd0;
        end
      end else if (scan_hit(cur_i.scan, regs_i.max_scan, lace)) begin
        t.row_start = cur_i.addr;
        t.scan      = 5'd0;
        t.row       = row_new;
        if ({1'b0, row_inc} == regs_i.v_disp) begin
          t.disp_active = 1'b0;
        end
        if (wrap) begin
          t.vadj_left = regs_i.v_adj;
          if (regs_i.v_adj == 8'd0) begin
            t.disp_active = 1'b1;
            t.addr        = start_addr;
            t.row_start   = start_addr;
          end
          if (regs_i.cur_start[6:5] == 2'b01) begin
            t.cursor_phase = 1'b0;
          end else begin
            t.cursor_phase = cur_i.blink[4];
          end
        end
        if ({1'b0, row_new} == regs_i.v_sync) begin
          t.disp_active = 1'b0;
          t.vsync_left  = VSYNC_LOAD;
          t.blink       = cur_i.blink + 5'd1;
        end
      end else begin
        t.scan = cur_i.scan + 5'd1;
        t.addr = cur_i.row_start;
      end

      // Open the cursor window on the updated scanline
      if (scan_hit(t.scan, {3'b000, regs_i.cur_start[4:0]}, lace)) begin
        t.cursor_window = 1'b1;
      end
    end
  end

  assign nxt_o = t;

endmodule

// ===== tb/text_crtc_timing_controller_tb.sv =====
// Self-checking testbench for the text CRT timing controller: port decode, raster timing, stalls.
module text_crtc_timing_controller_tb
  import tcrtc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNDEF       = 2'd3;
  localparam int unsigned HRETRACE_BIT  = 0;
  localparam int unsigned VSYNC_BIT     = 3;
  localparam logic [1:0] LACE_BOTH      = 2'b11;
  localparam logic [7:0] CUR_BLINK_MASK = 8'h60;
  localparam logic [7:0] CUR_BLINK_OFF  = 8'h20;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_CYCLES  = 5;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] row_address;
    logic [4:0]  scanline;
    logic        display_enable;
    logic        cursor_enable;
    logic        attr_blink_on;
    logic        vsync;
    logic        hretrace;
  } crtc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcrtc_in_if  in_ch();
  tcrtc_out_if out_ch();

  text_crtc_timing_controller DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the controller state
  logic [7:0]  crt_regs [NUM_REGS];
  logic [4:0]  reg_idx;
  logic [7:0]  mode_ctrl;
  logic [7:0]  status_reg;
  logic        line_phase;
  logic [6:0]  row_cnt;
  logic [4:0]  scan_cnt;
  logic [15:0] addr_cnt;
  logic [15:0] row_start;
  logic        cur_window;
  logic        cur_phase;
  logic        disp_on;
  logic [4:0]  blink_cnt;
  logic [4:0]  vs_left;
  logic [7:0]  vadj_left;

  crtc_result_t owed_results[$];
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  cycle_count = 0;
  logic         receiver_hold = 1'b0;
  event         hold_go;

  int unsigned send_idle_tbl [4] = '{0, 80, 0, 35};
  int unsigned stall_tbl     [4] = '{0, 0, 80, 35};

  // Scanline compare, also matching half the target in interlace mode
  function automatic logic scan_hits(logic [7:0] target);
    logic lace;
    lace = (crt_regs[R_LACE_MODE][1:0] == LACE_BOTH);
    return ({3'b000, scan_cnt} == target) || (lace && {3'b000, scan_cnt} == (target >> 1));
  endfunction

  // Work out the result beat for one input beat and advance the shadow state
  function automatic crtc_result_t crtc_respond(logic [1:0] op, logic [3:0] port,
                                                logic [7:0] data);
    crtc_result_t res;
    logic [6:0]   prev_row;
    logic [15:0]  frame_start;
    res.read_data      = '0;
    res.row_address    = addr_cnt;
    res.scanline       = scan_cnt;
    res.display_enable = disp_on;
    res.cursor_enable  = cur_window & cur_phase;
    res.attr_blink_on  = blink_cnt[4] & mode_ctrl[MODE_BLINK_BIT];
    res.vsync          = status_reg[VSYNC_BIT];
    res.hretrace       = status_reg[HRETRACE_BIT];
    frame_start = {2'b00, crt_regs[R_START_HI][5:0], crt_regs[R_START_LO]};
    case (op)
      OP_WRITE: begin
        if (port < PORT_MODE && !port[0]) begin
          reg_idx = data[4:0];
        end else if (port < PORT_MODE) begin
          crt_regs[reg_idx] = data;
          if (crt_regs[R_CUR_START] == CUR_FIX_START_IN &&
              crt_regs[R_CUR_END] == CUR_FIX_END_IN) begin
            crt_regs[R_CUR_START] = CUR_FIX_START_OUT;
            crt_regs[R_CUR_END]   = CUR_FIX_END_OUT;
          end
        end else if (port == PORT_MODE) begin
          mode_ctrl = data;
        end
      end
      OP_READ: begin
        if (port < PORT_MODE && !port[0])
          res.read_data = {3'b000, reg_idx};
        else if (port < PORT_MODE)
          res.read_data = crt_regs[reg_idx];
        else if (port == PORT_STATUS)
          res.read_data = status_reg | {STATUS_HI_ONES, 4'h0};
        else
          res.read_data = READ_NONE;
      end
      OP_TICK: begin
        if (!line_phase) begin
          // Line start: enter retrace, step the address, raise vsync on the sync row
          status_reg[HRETRACE_BIT] = 1'b1;
          line_phase = 1'b1;
          if (disp_on)
            addr_cnt = addr_cnt + {8'h00, crt_regs[R_H_DISP]};
          if ({1'b0, row_cnt} == crt_regs[R_V_SYNC] && scan_cnt == 5'd0)
            status_reg[VSYNC_BIT] = 1'b1;
        end else begin
          // Line end: count down vsync, close the cursor, advance scan and row
          if (disp_on)
            status_reg[HRETRACE_BIT] = 1'b0;
          line_phase = 1'b0;
          if (vs_left != 5'd0) begin
            vs_left = vs_left - 5'd1;
            if (vs_left == 5'd0)
              status_reg[VSYNC_BIT] = 1'b0;
          end
          if (scan_hits({3'b000, crt_regs[R_CUR_END][4:0]}))
            cur_window = 1'b0;
          if (vadj_left != 8'd0) begin
            scan_cnt  = scan_cnt + 5'd1;
            addr_cnt  = row_start;
            vadj_left = vadj_left - 8'd1;
            if (vadj_left == 8'd0) begin
              disp_on   = 1'b1;
              row_start = frame_start;
              addr_cnt  = frame_start;
              scan_cnt  = 5'd0;
            end
          end else if (scan_hits(crt_regs[R_MAX_SCAN])) begin
            prev_row  = row_cnt;
            row_start = addr_cnt;
            scan_cnt  = 5'd0;
            row_cnt   = row_cnt + 7'd1;
            if ({1'b0, row_cnt} == crt_regs[R_V_DISP])
              disp_on = 1'b0;
            if ({1'b0, prev_row} == crt_regs[R_V_TOTAL]) begin
              row_cnt   = 7'd0;
              vadj_left = crt_regs[R_V_ADJ];
              if (vadj_left == 8'd0) begin
                disp_on   = 1'b1;
                row_start = frame_start;
                addr_cnt  = frame_start;
              end
              if ((crt_regs[R_CUR_START] & CUR_BLINK_MASK) == CUR_BLINK_OFF)
                cur_phase = 1'b0;
              else
                cur_phase = blink_cnt[4];
            end
            if ({1'b0, row_cnt} == crt_regs[R_V_SYNC]) begin
              disp_on   = 1'b0;
              vs_left   = VSYNC_LOAD;
              blink_cnt = blink_cnt + 5'd1;
            end
          end else begin
            scan_cnt = scan_cnt + 5'd1;
            addr_cnt = row_start;
          end
          if (scan_hits({3'b000, crt_regs[R_CUR_START][4:0]}))
            cur_window = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one beat after a random gap, hold it until taken, then log its result
  task automatic send_beat(logic [1:0] op, logic [3:0] port, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.port_offset <= port;
    in_ch.write_data  <= data;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    owed_results.push_back(crtc_respond(op, port, data));
  endtask

  // Load one CRTC register through a random index port and a random data port
  task automatic write_reg(logic [4:0] idx, logic [7:0] val);
    send_beat(OP_WRITE, 4'(2 * $urandom_range(3)), {3'b000, idx});
    send_beat(OP_WRITE, 4'(2 * $urandom_range(3) + 1), val);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Take result beats, compare against the oldest expectation, drive ready
  always @(posedge clk_i) begin
    crtc_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        $error("result beat with nothing expected: read_data %0h", out_ch.read_data);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        check_field("read_data", want.read_data, out_ch.read_data);
        check_field("row_address", want.row_address, out_ch.row_address);
        check_field("scanline", want.scanline, out_ch.scanline);
        check_field("display_enable", want.display_enable, out_ch.display_enable);
        check_field("cursor_enable", want.cursor_enable, out_ch.cursor_enable);
        check_field("attr_blink_on", want.attr_blink_on, out_ch.attr_blink_on);
        check_field("vsync", want.vsync, out_ch.vsync);
        check_field("hretrace", want.hretrace, out_ch.hretrace);
      end
    end
    if (receiver_hold)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hold the receiver off for a long stretch on request
  initial forever begin
    @(hold_go);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    receiver_hold <= 1'b0;
  end

  // Abort a run that has hung
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Index and data ports, cursor fix-up, mode, status, unused ports, undefined op
  task automatic test_port_decode();
    send_beat(OP_WRITE, 4'd0, 8'hff);
    send_beat(OP_READ, 4'd2, 8'h00);
    send_beat(OP_WRITE, 4'd1, 8'ha5);
    send_beat(OP_READ, 4'd7, 8'h00);
    send_beat(OP_WRITE, 4'd9, 8'h55);
    send_beat(OP_WRITE, 4'd15, 8'haa);
    send_beat(OP_WRITE, PORT_MODE, 8'hff);
    send_beat(OP_READ, PORT_MODE, 8'h00);
    send_beat(OP_READ, PORT_STATUS, 8'h00);
    send_beat(OP_READ, 4'd15, 8'hff);
    send_beat(OP_UNDEF, 4'd5, 8'hff);
    write_reg(R_CUR_START, CUR_FIX_START_IN);
    write_reg(R_CUR_END, CUR_FIX_END_IN);
    send_beat(OP_READ, 4'd3, 8'h00);
    send_beat(OP_WRITE, 4'd6, {3'b000, R_CUR_START});
    send_beat(OP_READ, 4'd5, 8'h00);
    write_reg(R_LACE_MODE, {6'd0, LACE_BOTH});
    write_reg(R_MAX_SCAN, 8'hff);
    repeat (4) send_beat(OP_TICK, 4'd0, 8'h00);
    send_beat(OP_WRITE, PORT_MODE, 8'h00);
  endtask

  // Load a small random frame geometry so that frames wrap quickly
  task automatic program_timing();
    int unsigned v_total;
    v_total = $urandom_range(3);
    write_reg(R_H_DISP, 8'($urandom_range(255)));
    write_reg(R_V_TOTAL, 8'(v_total));
    write_reg(R_V_ADJ, 8'($urandom_range(3)));
    write_reg(R_V_DISP, 8'($urandom_range(v_total + 1)));
    write_reg(R_V_SYNC, 8'($urandom_range(v_total)));
    write_reg(R_LACE_MODE, 8'($urandom_range(3)));
    write_reg(R_MAX_SCAN, 8'($urandom_range(2)));
    write_reg(R_CUR_START, 8'(($urandom_range(3) << 5) | $urandom_range(3)));
    write_reg(R_CUR_END, 8'($urandom_range(3)));
    write_reg(R_START_HI, 8'($urandom_range(255)));
    write_reg(R_START_LO, 8'($urandom_range(255)));
    send_beat(OP_WRITE, PORT_MODE, 8'($urandom_range(255)));
  endtask

  // Run frames under each idle and stall pattern: mostly ticks, some reads and writes
  task automatic test_raster_timing();
    int unsigned pick;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_idle_tbl[phase];
      stall_pct     = stall_tbl[phase];
      program_timing();
      for (int n = 0; n < 110; n++) begin
        pick = $urandom_range(99);
        if (pick < 75)
          send_beat(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
        else if (pick < 88)
          send_beat(OP_READ, 4'($urandom_range(15)), 8'($urandom_range(255)));
        else if (pick < 94)
          send_beat(OP_WRITE, PORT_MODE, 8'($urandom_range(255)));
        else
          send_beat(OP_WRITE, 4'(2 * $urandom_range(3) + 1), 8'($urandom_range(3)));
      end
    end
  endtask

  // Keep offering beats while the receiver holds off, so the input stalls
  task automatic test_input_stall();
    send_idle_pct = 0;
    stall_pct     = 0;
    -> hold_go;
    for (int n = 0; n < 30; n++) begin
      if (n % 3 == 0)
        send_beat(OP_READ, 4'($urandom_range(15)), 8'($urandom_range(255)));
      else
        send_beat(OP_TICK, 4'd0, 8'h00);
    end
  endtask

  // Throw unconstrained beats at the block, undefined op included
  task automatic test_random_traffic();
    send_idle_pct = 35;
    stall_pct     = 35;
    for (int n = 0; n < 60; n++)
      send_beat(2'($urandom_range(3)), 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) crt_regs[i] = 8'h00;
    reg_idx    = '0;
    mode_ctrl  = '0;
    status_reg = '0;
    line_phase = 1'b0;
    row_cnt    = '0;
    scan_cnt   = '0;
    addr_cnt   = '0;
    row_start  = '0;
    cur_window = 1'b0;
    cur_phase  = 1'b0;
    disp_on    = 1'b0;
    blink_cnt  = '0;
    vs_left    = '0;
    vadj_left  = '0;

    in_ch.valid       = 1'b0;
    in_ch.op          = OP_WRITE;
    in_ch.port_offset = '0;
    in_ch.write_data  = '0;
    out_ch.ready      = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_port_decode();
    test_raster_timing();
    test_input_stall();
    test_random_traffic();

    // Drop valid, drain the outstanding results, then allow a little slack
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
